// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/salc_pkg.sv =====
package salc_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int NUM_SETS    = 64;
  localparam int NUM_WAYS    = 4;
  localparam int ADDR_BITS   = 32;

  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 7;
  localparam int OFF_BITS = $clog2(BLOCK_BYTES);
  localparam int SET_BITS = $clog2(NUM_SETS);
  localparam int TAG_BITS = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int WAY_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int AGE_BITS = 8;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // input command codes
  localparam logic CMD_CPU  = 1'b0;
  localparam logic CMD_FILL = 1'b1;

  // result destination codes
  localparam logic DEST_CPU = 1'b0;
  localparam logic DEST_MEM = 1'b1;

  // one RAM row holds a whole set
  typedef struct packed {
    logic [NUM_WAYS-1:0][TAG_BITS-1:0] tags;
    logic [NUM_WAYS-1:0]               valid;
    logic [NUM_WAYS-1:0][AGE_BITS-1:0] age;
  } row_t;

  typedef struct packed {
    logic hit;
    logic wr_en;
  } upd_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

// ===== rtl/salc_ram.sv =====
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/salc_set_update.sv =====
module salc_set_update (
  input  logic                         cmd,
  input  logic [salc_pkg::TAG_BITS-1:0] tag,
  input  logic                         row_written,
  input  salc_pkg::row_t               rd_row,
  output salc_pkg::row_t               new_row,
  output salc_pkg::upd_t               status
);

  import salc_pkg::*;

  row_t                row;
  logic                hit;
  logic [WAY_BITS-1:0] hit_way;
  logic [WAY_BITS-1:0] victim;
  logic [AGE_BITS-1:0] best_age;
  logic [WAY_BITS-1:0] sel;

  // a row never written since reset reads as all invalid, age zero
  always_comb begin
    row = rd_row;
    if (!row_written) begin
      row.valid = '0;
      row.age   = '0;
    end
  end

  // parallel tag compare, lowest matching way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row.valid[w] && row.tags[w] == tag) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
    end
  end

  // oldest way, ties to the highest index
  always_comb begin
    victim   = '0;
    best_age = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row.age[w] >= best_age) begin
        best_age = row.age[w];
        victim   = WAY_BITS'(w);
      end
    end
  end

  assign sel = hit ? hit_way : victim;

  always_comb begin
    new_row = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row.age[w] != AGE_MAX) begin
        new_row.age[w] = row.age[w] + AGE_BITS'(1);
      end
    end
    new_row.age[sel] = '0;
    if (cmd == CMD_FILL && !hit) begin
      new_row.tags[sel]  = tag;
      new_row.valid[sel] = 1'b1;
    end
  end

  assign status.hit   = hit;
  assign status.wr_en = hit || (cmd == CMD_FILL);

endmodule

// ===== rtl/set_assoc_lru_cache_tags_unit.sv =====
// A request is captured, and its set row read from the tag RAM, when it is accepted;
// in the lookup state the row is updated and written back and the result is registered.
// A new request is taken only after the lookup finishes.
// A waiting result sits in the output register; a back-pressured output holds the unit.
// Reset (synchronous, active high) clears the FSM, the output valid and the per-set
// written flags, so every set reads as empty with zero ages; RAM contents are not cleared.
module set_assoc_lru_cache_tags_unit (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [salc_pkg::ADDR_W-1:0]   addr,
  input  logic [salc_pkg::SIZE_W-1:0]   req_size,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          to_memory,
  output logic [salc_pkg::ADDR_W-1:0]   out_addr,
  output logic [salc_pkg::SIZE_W-1:0]   out_size
);

  import salc_pkg::*;

  state_t state, state_next;

  // request held across the lookup state
  logic                cmd_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [SIZE_W-1:0]   size_q;
  logic [SET_BITS-1:0] set_q;
  logic                row_written_q;

  // one flag per set: row has been written since reset
  logic [NUM_SETS-1:0] row_written;

  logic                accept;
  logic                finish;
  logic                out_free;
  logic [SET_BITS-1:0] in_set;
  logic [TAG_BITS-1:0] tag_q;

  row_t rd_row;
  row_t new_row;
  upd_t status;
  logic wr_en;

  assign in_set = addr[OFF_BITS +: SET_BITS];
  assign tag_q  = addr_q[ADDR_BITS-1 -: TAG_BITS];

  // ---------------- FSM ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    in_ready = 1'b0;
    finish   = 1'b0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_LOOKUP: finish   = out_free;
      default: begin
        in_ready = 1'b0;
        finish   = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- request capture ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q         <= cmd;
      addr_q        <= addr;
      size_q        <= req_size;
      set_q         <= in_set;
      row_written_q <= row_written[in_set];
    end
  end

  // ---------------- tag RAM: one row per set ----------------
  // Write-back happens at the end of the lookup state, before the next read
  // can be issued, so same-set requests never overlap.
  salc_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (set_q),
    .wr_data (new_row),
    .rd_en   (accept),
    .rd_addr (in_set),
    .rd_data (rd_row)
  );

  salc_set_update u_upd (
    .cmd         (cmd_q),
    .tag         (tag_q),
    .row_written (row_written_q),
    .rd_row      (rd_row),
    .new_row     (new_row),
    .status      (status)
  );

  assign wr_en = finish && status.wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
    end else if (wr_en) begin
      row_written[set_q] <= 1'b1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // miss on a CPU request goes to memory with its size; all else answers the CPU
  always_ff @(posedge clk) begin
    if (finish) begin
      out_addr <= addr_q;
      if (cmd_q == CMD_CPU && !status.hit) begin
        to_memory <= DEST_MEM;
        out_size  <= size_q;
      end else begin
        to_memory <= DEST_CPU;
        out_size  <= '0;
      end
    end
  end

endmodule

// ===== rtl/salc_checker.sv =====
`include "assert_macros.svh"

module salc_props (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [salc_pkg::ADDR_W-1:0] addr,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        to_memory,
  input logic [salc_pkg::ADDR_W-1:0] out_addr,
  input logic [salc_pkg::SIZE_W-1:0] out_size
);

  import salc_pkg::*;

  // stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_addr))

  // only a result bound for memory may carry a size
  `ASSERT_CLK(a_cpu_size, clk, rst, out_valid && to_memory == DEST_CPU |-> out_size == '0)

  // one request in flight: busy right after an accept
  `ASSERT_CLK(a_busy, clk, rst, in_valid && in_ready |=> !in_ready)

  // with a free output, the result for the accepted address appears once the lookup finishes
  `ASSERT_CLK(a_latency, clk, rst,
    in_valid && in_ready && !out_valid |-> ##2 (out_valid && out_addr == $past(addr, 2)))

  // reset empties the output
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid)

endmodule

bind set_assoc_lru_cache_tags_unit salc_props u_chk (.*);
